[rtl/fenwick_prefix_sum_table_assert.svh]
// Assertion macros shared by the prefix-sum table RTL.
// Depends on nothing; define NO_ASSERTIONS to compile every check away.
`ifndef FENWICK_PREFIX_SUM_TABLE_ASSERT_SVH
`define FENWICK_PREFIX_SUM_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Whenever cond holds, result must hold in the same cycle.
`define FPS_ASSERT_IMPL(label, clk, rst_n, cond, result, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (result)) \
		else $error(msg);

// Whenever cond holds, result must hold in the next cycle.
`define FPS_ASSERT_NEXT(label, clk, rst_n, cond, result, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (result)) \
		else $error(msg);

// The expression must never be true.
`define FPS_ASSERT_NEVER(label, clk, rst_n, bad, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) \
		else $error(msg);

`else

`define FPS_ASSERT_IMPL(label, clk, rst_n, cond, result, msg)
`define FPS_ASSERT_NEXT(label, clk, rst_n, cond, result, msg)
`define FPS_ASSERT_NEVER(label, clk, rst_n, bad, msg)

`endif

`endif

[rtl/fps_pkg.sv]
// Shared types and constants for the Fenwick prefix-sum table.
// Used by the front, queue, back and top-level modules; depends on nothing.
package fps_pkg;

	localparam int POS_W      = 11;  // width of a table position
	localparam int WALK_W     = POS_W + 1;  // walk position may step past the size
	localparam int DELTA_W    = 32;
	localparam int RESULT_W   = 32;
	localparam int SIZE_MAX   = (1 << POS_W) - 1;
	localparam logic [POS_W-1:0] SIZE_RESET = 11'd1024;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [1:0] {
		CMD_UPDATE,
		CMD_QUERY,
		CMD_REJECT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                  kind;
		logic [POS_W-1:0]           pos;
		logic signed [DELTA_W-1:0]  delta;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_LAST
	} back_state_t;

endpackage

[rtl/fps_front.sv]
// Front end of the prefix-sum table: accepts items and classifies them.
// Depends on fps_pkg.
module fps_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       clearing,
	input  logic [fps_pkg::POS_W-1:0]  eff_size,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       in_opcode,
	input  logic [fps_pkg::POS_W-1:0]  in_pos,
	input  logic [fps_pkg::DELTA_W-1:0] in_delta,
	output logic                       push,
	input  logic                       push_ready,
	output fps_pkg::cmd_t              push_cmd
);

	logic          valid_s1;
	fps_pkg::cmd_t cmd_s1;
	fps_pkg::cmd_t cmd_new;
	logic          in_xfer;

	// An update needs a nonzero position; both kinds must stay within the size.
	always_comb begin
		cmd_new.pos   = in_pos;
		cmd_new.delta = in_delta;
		if (in_pos > eff_size) begin
			cmd_new.kind = fps_pkg::CMD_REJECT;
		end else if (in_opcode == fps_pkg::OP_QUERY) begin
			cmd_new.kind = fps_pkg::CMD_QUERY;
		end else if (in_pos == '0) begin
			cmd_new.kind = fps_pkg::CMD_REJECT;
		end else begin
			cmd_new.kind = fps_pkg::CMD_UPDATE;
		end
	end

	assign in_ready = !clearing && (!valid_s1 || push_ready);
	assign in_xfer  = in_valid && in_ready;
	assign push     = valid_s1;
	assign push_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1 <= cmd_new;
		end
	end

endmodule

[rtl/fps_queue.sv]
// Short command queue between the front end and the table walker.
// Depends on fps_pkg and the assertion macro header.
`include "fenwick_prefix_sum_table_assert.svh"

module fps_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          push_ready,
	input  fps_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop,
	output fps_pkg::cmd_t pop_cmd
);

	fps_pkg::cmd_t                 entry_q [fps_pkg::QUEUE_DEPTH];
	logic [fps_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [fps_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [fps_pkg::QCNT_W-1:0]    count_q;
	logic                          do_push;
	logic                          do_pop;

	assign push_ready = count_q != fps_pkg::QCNT_W'(fps_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	`FPS_ASSERT_NEVER(a_queue_over, clk, arst_n, count_q > fps_pkg::QCNT_W'(fps_pkg::QUEUE_DEPTH), "queue count past depth")
	`FPS_ASSERT_IMPL(a_pop_nonempty, clk, arst_n, pop, pop_valid, "pop from an empty queue")
	`FPS_ASSERT_NEXT(a_count_push, clk, arst_n, do_push && !do_pop, count_q != '0, "push left queue empty")

endmodule

[rtl/fps_back.sv]
// Back end of the prefix-sum table: walks the partial-sum memory for one
// command at a time and holds the result. Depends on fps_pkg and the macro header.
`include "fenwick_prefix_sum_table_assert.svh"

module fps_back #(
	parameter int TABLE_DEPTH = 1024,
	parameter int SUM_WIDTH   = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [fps_pkg::POS_W-1:0]     eff_size,
	output logic                          clearing,
	input  logic                          cmd_valid,
	input  fps_pkg::cmd_t                 cmd,
	output logic                          cmd_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fps_pkg::RESULT_W-1:0]  out_sum,
	output logic                          out_err
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic [SUM_WIDTH-1:0] mem [TABLE_DEPTH];

	fps_pkg::back_state_t          state_q, state_nxt;
	logic [fps_pkg::WALK_W-1:0]    walk_q;
	fps_pkg::cmd_kind_t            kind_q;
	logic [SUM_WIDTH-1:0]          delta_q;
	logic [SUM_WIDTH-1:0]          acc_q;
	logic                          pend_q;
	logic [AW-1:0]                 pend_addr_q;
	logic [AW-1:0]                 clr_q;
	logic [SUM_WIDTH-1:0]          rdata_q;
	logic                          out_valid_q;
	logic [fps_pkg::RESULT_W-1:0]  out_sum_q;
	logic                          out_err_q;

	logic                          is_update;
	logic                          step;
	logic [fps_pkg::WALK_W-1:0]    low_bit;
	logic [fps_pkg::WALK_W-1:0]    walk_nxt;
	logic                          clr_last;
	logic [SUM_WIDTH-1:0]          acc_sum;
	logic signed [fps_pkg::DELTA_W-1:0] cmd_delta;

	logic                          mem_we;
	logic [AW-1:0]                 mem_waddr;
	logic [SUM_WIDTH-1:0]          mem_wdata;
	logic                          mem_re;
	logic [AW-1:0]                 mem_raddr;
	logic                          load_out;

	assign is_update = kind_q == fps_pkg::CMD_UPDATE;
	assign step      = is_update ? (walk_q <= {1'b0, eff_size}) : (walk_q != '0);
	assign low_bit   = walk_q & (~walk_q + 1'b1);
	assign walk_nxt  = is_update ? (walk_q + low_bit) : (walk_q & (walk_q - 1'b1));
	assign clr_last  = clr_q == AW'(TABLE_DEPTH - 1);
	assign acc_sum   = (pend_q && !is_update) ? (acc_q + rdata_q) : acc_q;
	assign cmd_delta = cmd.delta;

	// Next-state logic.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			fps_pkg::ST_CLEAR: if (clr_last) state_nxt = fps_pkg::ST_IDLE;
			fps_pkg::ST_IDLE: begin
				if (cmd_pop && cmd.kind != fps_pkg::CMD_REJECT) begin
					state_nxt = fps_pkg::ST_WALK;
				end
			end
			fps_pkg::ST_WALK: if (!step) state_nxt = fps_pkg::ST_LAST;
			fps_pkg::ST_LAST: state_nxt = fps_pkg::ST_IDLE;
			default: state_nxt = fps_pkg::ST_IDLE;
		endcase
	end

	// Memory controls and handshake outputs. A walk reads one entry per
	// cycle; the write-back of an update follows in the cycle after its read.
	always_comb begin
		cmd_pop   = (state_q == fps_pkg::ST_IDLE) && cmd_valid
			&& (cmd.kind == fps_pkg::CMD_UPDATE || !out_valid_q);
		mem_re    = (state_q == fps_pkg::ST_WALK) && step;
		mem_raddr = AW'(walk_q - 1'b1);
		mem_we    = 1'b0;
		mem_waddr = pend_addr_q;
		mem_wdata = rdata_q + delta_q;
		load_out  = 1'b0;
		unique case (state_q)
			fps_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			fps_pkg::ST_IDLE: load_out = cmd_pop && cmd.kind == fps_pkg::CMD_REJECT;
			fps_pkg::ST_WALK: mem_we = pend_q && is_update;
			fps_pkg::ST_LAST: begin
				mem_we   = pend_q && is_update;
				load_out = !is_update;
			end
			default: mem_we = 1'b0;
		endcase
	end

	assign clearing  = state_q == fps_pkg::ST_CLEAR;
	assign out_valid = out_valid_q;
	assign out_sum   = out_sum_q;
	assign out_err   = out_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fps_pkg::ST_CLEAR;
			clr_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == fps_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			pend_q <= mem_re;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			walk_q  <= {1'b0, cmd.pos};
			kind_q  <= cmd.kind;
			delta_q <= SUM_WIDTH'(cmd_delta);
			acc_q   <= '0;
		end else if (state_q == fps_pkg::ST_WALK) begin
			acc_q <= acc_sum;
			if (step) begin
				walk_q <= walk_nxt;
			end
		end
		pend_addr_q <= mem_raddr;
		if (load_out) begin
			out_err_q <= state_q == fps_pkg::ST_IDLE;
			out_sum_q <= (state_q == fps_pkg::ST_IDLE) ? '0 : fps_pkg::RESULT_W'(acc_sum);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	`FPS_ASSERT_IMPL(a_no_pop_clear, clk, arst_n, state_q == fps_pkg::ST_CLEAR, !cmd_pop, "command taken during clear")
	`FPS_ASSERT_IMPL(a_rw_distinct, clk, arst_n, mem_we && mem_re, mem_waddr != mem_raddr, "read and write collide")
	`FPS_ASSERT_IMPL(a_load_empty, clk, arst_n, load_out, !out_valid_q, "result overwrites a pending result")
	`FPS_ASSERT_IMPL(a_pend_walk, clk, arst_n, pend_q, state_q == fps_pkg::ST_WALK || state_q == fps_pkg::ST_LAST, "read data outside a walk")

endmodule

[rtl/fenwick_prefix_sum_table.sv]
// Fenwick (binary indexed) prefix-sum table, top level; uses fps_pkg, fps_front,
// fps_queue and fps_back. An item passes the front register and the queue before it
// reaches the walker, which visits up to 11 table entries at a depth of 1024, one memory
// read per walk step, and takes the next item only once the last walk is through. After
// reset the memory is cleared one entry per cycle, with s_tready held low.
//
// Structure: a front stage classifies each transfer (update, query, or rejected
// position) against the effective size, a two-entry queue decouples it from the
// walker, and the walker steps through the memory, one read per cycle. Updates
// write back each entry in the cycle after reading it, so a walk never stalls.
// A rejected position is answered in the idle state, with no walk. The memory has one
// read port and one write port.
// Results wait in an output register; items are taken until the front and the queue fill.
module fenwick_prefix_sum_table #(
	parameter int TABLE_DEPTH = 1024,
	parameter int SUM_WIDTH   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: size_in_use.
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	// Input items.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [10:0] position, [42:11] delta, [47:43] zero
	input  logic        s_tuser,   // [0] opcode: 0 add, 1 query
	// Results.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] prefix_sum
	output logic        m_tuser    // [0] range_error
);

	// A configured size above the table depth is held at the depth (at most SIZE_MAX).
	localparam int SIZE_CAP = (TABLE_DEPTH > fps_pkg::SIZE_MAX) ? fps_pkg::SIZE_MAX
		: TABLE_DEPTH;

	logic [fps_pkg::POS_W-1:0] size_in_use_q;
	logic [fps_pkg::POS_W-1:0] eff_size;
	logic                      clearing;
	logic                      push;
	logic                      push_ready;
	fps_pkg::cmd_t             push_cmd;
	logic                      pop_valid;
	logic                      pop;
	fps_pkg::cmd_t             pop_cmd;

	// The user must write the size register only while the block is idle (the block
	// does not enforce it), so both the front and the walker can read it live.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_in_use_q <= fps_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			size_in_use_q <= cfg_wdata;
		end
	end

	assign eff_size = (size_in_use_q > fps_pkg::POS_W'(SIZE_CAP))
		? fps_pkg::POS_W'(SIZE_CAP) : size_in_use_q;

	fps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.clearing   (clearing),
		.eff_size   (eff_size),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_opcode  (s_tuser),
		.in_pos     (s_tdata[10:0]),
		.in_delta   (s_tdata[42:11]),
		.push       (push),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	fps_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_cmd    (pop_cmd)
	);

	fps_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.SUM_WIDTH   (SUM_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.eff_size  (eff_size),
		.clearing  (clearing),
		.cmd_valid (pop_valid),
		.cmd       (pop_cmd),
		.cmd_pop   (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_sum   (m_tdata),
		.out_err   (m_tuser)
	);

endmodule

[bench/tb_top.sv]
// Self-checking bench for the Fenwick prefix-sum table: a directed table of
// updates and queries, then random traffic under several sizes and flow patterns.
// Depends on fps_pkg and the fenwick_prefix_sum_table top level only.
`timescale 1ns / 100ps

module tb_top;

	localparam int DEPTH       = 1024;
	localparam int CYCLE_LIMIT = 400000;  // includes the clearing pass after reset
	localparam int DRAIN_WAIT  = 100;     // covers a full queue of walks that give no result
	localparam int HOLD_CYCLES = 400;     // long receiver hold-off used once

	typedef enum int {
		FLOW_FREE,
		FLOW_SENDER_IDLE,
		FLOW_RECEIVER_STALL,
		FLOW_BOTH
	} flow_mode_t;

	typedef struct packed {
		logic [fps_pkg::RESULT_W-1:0] prefix_sum;
		logic                         range_error;
	} table_result_t;

	// One directed row; when known is set, the expected result is typed in here.
	typedef struct packed {
		logic                         op;
		logic [fps_pkg::POS_W-1:0]    pos;
		logic [fps_pkg::DELTA_W-1:0]  delta;
		logic                         known;
		logic [fps_pkg::RESULT_W-1:0] sum;
		logic                         err;
	} probe_row_t;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [fps_pkg::POS_W-1:0]    cfg_wdata;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [47:0]                  s_tdata;
	logic                         s_tuser;
	logic                         m_tvalid;
	logic                         m_tready;
	logic [fps_pkg::RESULT_W-1:0] m_tdata;
	logic                         m_tuser;

	// Shadow of the table and of the size register.
	logic [fps_pkg::RESULT_W-1:0] shadow_sums [1:DEPTH];
	logic [fps_pkg::POS_W-1:0]    shadow_size;
	table_result_t                expected_sums [$];

	int  tx_idle_pct  = 0;
	int  rx_stall_pct = 0;
	bit  hold_req     = 1'b0;
	int  mismatches   = 0;
	int  cycle_count  = 0;

	fenwick_prefix_sum_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int effective_size();
		return (int'(shadow_size) > DEPTH) ? DEPTH : int'(shadow_size);
	endfunction

	// Applies one item to the shadow table; has_res tells whether a result follows.
	function automatic void predict_fenwick_op(input logic op,
			input logic [fps_pkg::POS_W-1:0] pos, input logic [fps_pkg::DELTA_W-1:0] delta,
			output bit has_res, output table_result_t res);
		int unsigned                  p;
		int unsigned                  lim;
		logic [fps_pkg::RESULT_W-1:0] acc;
		p       = 32'(pos);
		lim     = effective_size();
		acc     = '0;
		has_res = 1'b1;
		res     = '{prefix_sum: '0, range_error: 1'b1};
		if (op == fps_pkg::OP_ADD) begin
			if (p == 0 || p > lim)
				return;
			while (p <= lim) begin
				shadow_sums[p] = shadow_sums[p] + delta;
				p = p + (p & (~p + 1));
			end
			has_res = 1'b0;
		end else begin
			if (p > lim)
				return;
			while (p > 0) begin
				acc = acc + shadow_sums[p];
				p = p - (p & (~p + 1));
			end
			res = '{prefix_sum: acc, range_error: 1'b0};
		end
	endfunction

	task automatic set_flow(input flow_mode_t mode);
		case (mode)
			FLOW_FREE: begin
				tx_idle_pct = 0;  rx_stall_pct = 0;
			end
			FLOW_SENDER_IDLE: begin
				tx_idle_pct = 86; rx_stall_pct = 0;
			end
			FLOW_RECEIVER_STALL: begin
				tx_idle_pct = 0;  rx_stall_pct = 86;
			end
			default: begin
				tx_idle_pct = 13; rx_stall_pct = 13;
			end
		endcase
	endtask

	// Offers one item, waits for its transfer, then records what it should give.
	task automatic offer_item(input logic op, input logic [fps_pkg::POS_W-1:0] pos,
			input logic [fps_pkg::DELTA_W-1:0] delta, input bit known,
			input table_result_t typed);
		bit            has_res;
		table_result_t res;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {5'b0, delta, pos};
		do @(posedge clk); while (!s_tready);
		predict_fenwick_op(op, pos, delta, has_res, res);
		if (has_res)
			expected_sums.push_back(known ? typed : res);
	endtask

	// Lowers valid in the step of the last transfer, then lets every walk finish.
	task automatic drain_block();
		s_tvalid <= 1'b0;
		while (expected_sums.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_size(input logic [fps_pkg::POS_W-1:0] value);
		drain_block();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we      <= 1'b0;
		shadow_size  = value;
	endtask

	// Mostly in-range positions with random deltas; the rest is positions anywhere in the
	// 11-bit range, zero positions, the size itself, and the extremes of the delta.
	task automatic random_item();
		logic                        op;
		logic [fps_pkg::POS_W-1:0]   pos;
		logic [fps_pkg::DELTA_W-1:0] delta;
		int                          lim;
		int                          pick;
		lim  = effective_size();
		pick = $urandom_range(99);
		op   = 1'($urandom_range(1));
		if (lim == 0 || pick < 8)
			pos = fps_pkg::POS_W'($urandom_range(2047));
		else if (pick < 12)
			pos = '0;
		else if (pick < 20)
			pos = fps_pkg::POS_W'(lim);
		else
			pos = fps_pkg::POS_W'($urandom_range(lim, 1));
		case ($urandom_range(15))
			0:       delta = 32'h8000_0000;
			1:       delta = 32'h7FFF_FFFF;
			2:       delta = 32'hFFFF_FFFF;
			default: delta = $urandom;
		endcase
		offer_item(op, pos, delta, 1'b0, '0);
	endtask

	task automatic run_phase(input logic [fps_pkg::POS_W-1:0] size, input int count,
			input flow_mode_t mode);
		write_size(size);
		set_flow(mode);
		repeat (count) random_item();
	endtask

	// Receiver side: random stalls, plus one long hold-off on request.
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		m_tready  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// Result checker: every transfer on the master side is matched in order.
	always @(posedge clk) begin
		table_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_sums.size() == 0) begin
				mismatches++;
				$display("%0t: result with none expected: prefix_sum %h range_error %b",
					$time, m_tdata, m_tuser);
			end else begin
				want = expected_sums.pop_front();
				if (m_tdata !== want.prefix_sum) begin
					mismatches++;
					$display("%0t: prefix_sum expected %h actual %h",
						$time, want.prefix_sum, m_tdata);
				end
				if (m_tuser !== want.range_error) begin
					mismatches++;
					$display("%0t: range_error expected %b actual %b",
						$time, want.range_error, m_tuser);
				end
			end
		end
	end

	// Directed rows, at the reset size of 1024.
	probe_row_t directed_rows [20] = '{
		'{fps_pkg::OP_QUERY, 11'd0,    32'h1234_5678, 1'b1, 32'h0, 1'b0},
		'{fps_pkg::OP_QUERY, 11'd1024, 32'h0,         1'b1, 32'h0, 1'b0},
		'{fps_pkg::OP_QUERY, 11'd1,    32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0},
		'{fps_pkg::OP_ADD,   11'd0,    32'h0000_0005, 1'b1, 32'h0, 1'b1},
		'{fps_pkg::OP_ADD,   11'd1025, 32'h0000_0005, 1'b1, 32'h0, 1'b1},
		'{fps_pkg::OP_QUERY, 11'd2047, 32'h0,         1'b1, 32'h0, 1'b1},
		'{fps_pkg::OP_ADD,   11'd2047, 32'h7FFF_FFFF, 1'b1, 32'h0, 1'b1},
		'{fps_pkg::OP_ADD,   11'd1536, 32'h0000_0001, 1'b1, 32'h0, 1'b1},
		'{fps_pkg::OP_ADD,   11'd1,    32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
		'{fps_pkg::OP_ADD,   11'd1,    32'h0000_0001, 1'b0, 32'h0, 1'b0},
		'{fps_pkg::OP_QUERY, 11'd1,    32'h0,         1'b0, 32'h0, 1'b0},
		'{fps_pkg::OP_ADD,   11'd1024, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
		'{fps_pkg::OP_ADD,   11'd512,  32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
		'{fps_pkg::OP_ADD,   11'd1023, 32'h5555_5555, 1'b0, 32'h0, 1'b0},
		'{fps_pkg::OP_ADD,   11'd1000, 32'hAAAA_AAAA, 1'b0, 32'h0, 1'b0},
		'{fps_pkg::OP_QUERY, 11'd1024, 32'h0,         1'b0, 32'h0, 1'b0},
		'{fps_pkg::OP_QUERY, 11'd1023, 32'h0,         1'b0, 32'h0, 1'b0},
		'{fps_pkg::OP_QUERY, 11'd512,  32'h0,         1'b0, 32'h0, 1'b0},
		'{fps_pkg::OP_QUERY, 11'd1000, 32'h0,         1'b0, 32'h0, 1'b0},
		'{fps_pkg::OP_QUERY, 11'd513,  32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0}
	};

	initial begin
		table_result_t typed;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = 1'b0;
		shadow_size = fps_pkg::SIZE_RESET;
		for (int i = 1; i <= DEPTH; i++)
			shadow_sums[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		set_flow(FLOW_FREE);
		foreach (directed_rows[i]) begin
			typed = '{prefix_sum: directed_rows[i].sum, range_error: directed_rows[i].err};
			offer_item(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].delta,
				directed_rows[i].known, typed);
		end

		run_phase(11'd1,    150, FLOW_SENDER_IDLE);
		run_phase(11'd2047, 180, FLOW_RECEIVER_STALL);
		run_phase(11'd0,     40, FLOW_BOTH);
		run_phase(11'($urandom_range(1022, 3)), 180, FLOW_BOTH);

		// The receiver holds off while items keep coming, so the queue fills
		// and the input side has to stall.
		write_size(11'd1023);
		set_flow(FLOW_FREE);
		hold_req = 1'b1;
		repeat (180) random_item();

		run_phase(11'd2,    100, FLOW_RECEIVER_STALL);
		run_phase(11'd512,  180, FLOW_SENDER_IDLE);
		run_phase(11'd1024, 200, FLOW_FREE);

		drain_block();
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
